// File: rtl/core/msequence_lfsr_generator_unit_macros.svh
// Assertion macros shared by the m-sequence generator RTL.
// Included by the top level only; needs no other file.
`ifndef MSEQUENCE_LFSR_GENERATOR_UNIT_MACROS_SVH
`define MSEQUENCE_LFSR_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MSQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/msq_pkg.sv
// Package for the m-sequence generator: widths, register indexes, output
// modes and the control structs passed between the top level and its cells.
package msq_pkg;

  localparam int MAX_BITS_DEF = 31;
  localparam int NBITS_W      = 5;
  localparam int OUT_W        = 31;
  localparam int HOLD_W       = 16;
  localparam int TDATA_W      = 64;

  localparam logic [1:0] REG_NBITS = 2'd0;
  localparam logic [1:0] REG_TAPS  = 2'd1;
  localparam logic [1:0] REG_MODE  = 2'd2;
  localparam logic [1:0] REG_HOLD  = 2'd3;

  localparam logic [1:0] MODE_FULL    = 2'd0;
  localparam logic [1:0] MODE_LSB     = 2'd1;
  localparam logic [1:0] MODE_BIPOLAR = 2'd2;

  localparam logic [NBITS_W-1:0] NBITS_RESET = 5'd10;
  localparam logic [31:0]        TAPS_RESET  = 32'd1033;
  localparam logic [1:0]         MODE_RESET  = MODE_FULL;
  localparam logic [HOLD_W-1:0]  HOLD_RESET  = 16'd1;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic               en;       // an item is accepted this cycle
    logic               restart;  // reload to 1 before the result is formed
    logic               load;     // end of period: reload after this item
    logic               shift;    // end of hold: advance both registers
    logic [NBITS_W-1:0] nbits;    // effective register length
    logic               fb;       // tap-form feedback bit
    logic               par;      // generating-form parity
  } msq_cell_ctrl_t;

  // Returned by each cell.
  typedef struct packed {
    logic gen_q;    // stored generating bit
    logic gen_eff;  // generating bit after restart, masked to the length
    logic tap_eff;  // tap bit after restart
    logic par_bit;  // contribution to the parity
    logic fb_bit;   // tap bit of the top cell, zero elsewhere
    logic active;   // cell lies below the register length
  } msq_cell_out_t;

endpackage

// File: rtl/core/msq_cell.sv
// One bit of both feedback registers of the m-sequence generator.
// Depends on msq_pkg for the control and status structs.
module msq_cell #(
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   gen_up,
  input  logic                   tap_dn,
  input  logic                   tap_sel,
  input  msq_pkg::msq_cell_ctrl_t ctrl,
  output msq_pkg::msq_cell_out_t  status
);

  localparam logic SEED = (IDX == 0) ? 1'b1 : 1'b0;

  logic gen_bit;
  logic tap_bit;
  logic gen_bit_next;
  logic tap_bit_next;
  logic active;
  logic is_top;
  logic gen_eff;
  logic tap_eff;

  assign active  = (6'(IDX) < {1'b0, ctrl.nbits});
  assign is_top  = ((6'(IDX) + 6'd1) == {1'b0, ctrl.nbits});
  assign gen_eff = (ctrl.restart ? SEED : gen_bit) & active;
  assign tap_eff = ctrl.restart ? SEED : tap_bit;

  always_comb begin
    gen_bit_next = gen_bit;
    tap_bit_next = tap_bit;
    if (ctrl.en) begin
      if (ctrl.load) begin
        gen_bit_next = SEED;
        tap_bit_next = SEED;
      end else if (ctrl.shift) begin
        // The cell above hands down its masked bit; the top cell takes the parity.
        gen_bit_next = is_top ? ctrl.par : gen_up;
        tap_bit_next = tap_dn ^ (ctrl.fb & tap_sel);
      end else begin
        gen_bit_next = ctrl.restart ? SEED : gen_bit;
        tap_bit_next = tap_eff;
      end
    end
  end

  // Payload bits: the reset value is restored by the top level's reload.
  always_ff @(posedge clk) begin
    gen_bit <= gen_bit_next;
    tap_bit <= tap_bit_next;
  end

  assign status.gen_q   = gen_bit;
  assign status.gen_eff = gen_eff;
  assign status.tap_eff = tap_eff;
  assign status.par_bit = gen_eff & tap_sel;
  assign status.fb_bit  = tap_eff & is_top;
  assign status.active  = active;

endmodule

// File: rtl/core/msq_skid.sv
// Two-entry output buffer for the result stream: an output register and a
// skid register. Generic in width; needs no package.
module msq_skid #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         in_acc;
  logic         out_free;

  assign in_ready = !skid_valid;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_acc;
      skid_valid <= 1'b0;
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_acc) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: rtl/core/msequence_lfsr_generator_unit.sv
// Top level of the m-sequence generator: configuration port, hold and period
// counters, the chain of register cells and the result buffer.
// Depends on msq_pkg, msq_cell, msq_skid and the macros header.
//
//   channel   direction  handshake              payload
//   s_*       in         s_tvalid / s_tready    s_tdata[0] restart
//   m_*       out        m_tvalid / m_tready    m_tdata, m_tlast period end
//   apb       in         psel & penable         paddr, pwdata, prdata
//
// Every accepted item gives one result, registered in the output buffer, at one
// item per cycle while the result sink is ready.
// Reset (rst, synchronous) restores the registers' reset values and empties
// the output buffer; the first item may follow in the next cycle.
// A stalled result sink lets one more item in; s_tready then drops.
`include "msequence_lfsr_generator_unit_macros.svh"

module msequence_lfsr_generator_unit #(
  parameter int MAX_BITS = msq_pkg::MAX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [30:0] gen_word, [61:31] tap_word, [63:62] bipolar_value
  output logic        m_tlast    // period_end
);

  localparam int LIM = (MAX_BITS < 31) ? MAX_BITS : 31;
  localparam int NW  = msq_pkg::NBITS_W;
  localparam int HW  = msq_pkg::HOLD_W;
  localparam int OW  = msq_pkg::OUT_W;
  localparam int DW  = msq_pkg::TDATA_W;

  // Configuration registers.
  logic [NW-1:0] register_bits;
  logic [31:0]   tap_mask;
  logic [1:0]    output_mode;
  logic [HW-1:0] hold_count;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      register_bits <= msq_pkg::NBITS_RESET;
      tap_mask      <= msq_pkg::TAPS_RESET;
      output_mode   <= msq_pkg::MODE_RESET;
      hold_count    <= msq_pkg::HOLD_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        msq_pkg::REG_NBITS: register_bits <= pwdata[NW-1:0];
        msq_pkg::REG_TAPS:  tap_mask      <= pwdata;
        msq_pkg::REG_MODE:  output_mode   <= pwdata[1:0];
        msq_pkg::REG_HOLD:  hold_count    <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      msq_pkg::REG_NBITS: prdata = 32'(register_bits);
      msq_pkg::REG_TAPS:  prdata = tap_mask;
      msq_pkg::REG_MODE:  prdata = 32'(output_mode);
      msq_pkg::REG_HOLD:  prdata = 32'(hold_count);
      default:            prdata = 32'd0;
    endcase
  end

  // Effective length and hold.
  logic [NW-1:0] nbits;
  logic [HW-1:0] hold;

  always_comb begin
    if (register_bits > NW'(LIM)) begin
      nbits = NW'(LIM);
    end else if (register_bits < NW'(2)) begin
      nbits = NW'(2);
    end else begin
      nbits = register_bits;
    end
    hold = (hold_count == '0) ? HW'(1) : hold_count;
  end

  // Input side and counters.
  logic          in_acc;
  logic          buf_ready;
  logic          restart;
  logic [HW-1:0] hold_counter;
  logic [HW-1:0] hold_counter_next;
  logic [LIM-1:0] step_index;
  logic [LIM-1:0] step_index_next;
  logic [HW-1:0] hc_eff;
  logic [LIM-1:0] si_eff;
  logic          end_hold;
  logic          end_period;

  assign s_tready = buf_ready;
  assign in_acc   = s_tvalid && s_tready;
  assign restart  = s_tdata[0];
  assign hc_eff   = restart ? '0 : hold_counter;
  assign si_eff   = restart ? '0 : step_index;

  // Cell chain status gathered into vectors.
  msq_pkg::msq_cell_ctrl_t ctrl;
  msq_pkg::msq_cell_out_t  cell_st [LIM+1];
  logic [LIM:0] gen_q_v;
  logic [LIM:0] gen_v;
  logic [LIM:0] tap_v;
  logic [LIM:0] par_v;
  logic [LIM:0] fb_v;
  logic [LIM:0] act_v;

  always_comb begin
    for (int i = 0; i <= LIM; i++) begin
      gen_q_v[i] = cell_st[i].gen_q;
      gen_v[i]   = cell_st[i].gen_eff;
      tap_v[i]   = cell_st[i].tap_eff;
      par_v[i]   = cell_st[i].par_bit;
      fb_v[i]    = cell_st[i].fb_bit;
      act_v[i]   = cell_st[i].active;
    end
  end

  assign end_hold   = ({1'b0, hc_eff} + (HW+1)'(1)) >= {1'b0, hold};
  assign end_period = end_hold &&
                      (({1'b0, si_eff} + (LIM+1)'(1)) >= {1'b0, act_v[LIM-1:0]});

  always_comb begin
    hold_counter_next = hold_counter;
    step_index_next   = step_index;
    if (in_acc) begin
      if (end_hold) begin
        hold_counter_next = '0;
        step_index_next   = end_period ? '0 : si_eff + LIM'(1);
      end else begin
        hold_counter_next = hc_eff + HW'(1);
        step_index_next   = si_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_counter <= '0;
      step_index   <= '0;
    end else begin
      hold_counter <= hold_counter_next;
      step_index   <= step_index_next;
    end
  end

  // Register reset to 1 is done through the cells' reload path.
  assign ctrl.en      = in_acc || rst;
  assign ctrl.restart = restart;
  assign ctrl.load    = end_period || rst;
  assign ctrl.shift   = end_hold && !end_period;
  assign ctrl.nbits   = nbits;
  assign ctrl.fb      = |fb_v;
  assign ctrl.par     = ^par_v;

  for (genvar i = 0; i <= LIM; i++) begin : g_cell
    logic gen_up;
    logic tap_dn;
    if (i < LIM) begin : g_up
      assign gen_up = cell_st[i+1].gen_eff;
    end else begin : g_up_top
      assign gen_up = 1'b0;
    end
    if (i > 0) begin : g_dn
      assign tap_dn = cell_st[i-1].tap_eff;
    end else begin : g_dn_low
      assign tap_dn = 1'b0;
    end
    msq_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .gen_up  (gen_up),
      .tap_dn  (tap_dn),
      .tap_sel (tap_mask[i]),
      .ctrl    (ctrl),
      .status  (cell_st[i])
    );
  end

  // Result formatting.
  logic [OW-1:0] gen_word;
  logic [OW-1:0] tap_word;
  logic [1:0]    bipolar_value;
  logic          lsb;

  assign lsb = gen_v[0];

  always_comb begin
    gen_word      = OW'(lsb);
    tap_word      = '0;
    bipolar_value = 2'sd0;
    unique case (output_mode)
      msq_pkg::MODE_FULL: begin
        gen_word = OW'(gen_v[LIM-1:0]);
        tap_word = OW'(tap_v[LIM-1:0] & act_v[LIM-1:0]);
      end
      msq_pkg::MODE_BIPOLAR: begin
        bipolar_value = lsb ? 2'b11 : 2'b01;
      end
      default: ;
    endcase
  end

  msq_skid #(
    .W (DW + 1)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (buf_ready),
    .in_data   ({end_period, bipolar_value, tap_word, gen_word}),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  ({m_tlast, m_tdata})
  );

  `MSQ_ASSERT_IMP(a_stall_holds_result, clk, rst, !s_tready, m_tvalid)
  `MSQ_ASSERT_NEXT(a_period_clears, clk, rst, in_acc && end_period,
                   step_index == '0 && hold_counter == '0)
  `MSQ_ASSERT_NEXT(a_hold_keeps_state, clk, rst, in_acc && !restart && !end_hold,
                   gen_q_v == $past(gen_q_v))

endmodule
